@@ hdl/i2cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cbe_pkg
// shared types and constants for the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cbe_pkg;

    localparam int UNIT_W  = 12;
    localparam int LIMIT_W = 8;
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int UCNT_W  = 3;
    localparam int BIT_W   = 4;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [UNIT_W-1:0]  UNIT_TICKS_RST     = 12'd250;
    localparam logic [LIMIT_W-1:0] ACK_POLL_LIMIT_RST = 8'd250;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 1'b1;

    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SEND  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    // delay lengths in units
    localparam logic [UCNT_W-1:0] UNITS_4 = 3'd4;
    localparam logic [UCNT_W-1:0] UNITS_2 = 3'd2;
    localparam logic [UCNT_W-1:0] UNITS_1 = 3'd1;
    localparam logic [UCNT_W-1:0] UNITS_0 = 3'd0;

    localparam logic [BIT_W-1:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [15:0] {
        PH_IDLE = 16'h0001,
        PH_ST1  = 16'h0002,
        PH_ST2  = 16'h0004,
        PH_SP1  = 16'h0008,
        PH_SP2  = 16'h0010,
        PH_SP3  = 16'h0020,
        PH_TXD  = 16'h0040,
        PH_TXH  = 16'h0080,
        PH_TXL  = 16'h0100,
        PH_WA1  = 16'h0200,
        PH_WA2  = 16'h0400,
        PH_POLL = 16'h0800,
        PH_RDL  = 16'h1000,
        PH_RDH  = 16'h2000,
        PH_AKL  = 16'h4000,
        PH_AKH  = 16'h8000
    } phase_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_fail;
    } result_t;

endpackage

@@ hdl/i2cbe_core.sv @@
// ----------------------------------------------------------------------------
// i2cbe_core
// bus sequencer: timing counters, phase state and next-tick update
// ----------------------------------------------------------------------------
module i2cbe_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [i2cbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cbe_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            take,
    input  logic [i2cbe_pkg::CMD_W-1:0]     cmd,
    input  logic [i2cbe_pkg::BYTE_W-1:0]    tx_byte,
    input  logic                            send_ack,
    input  logic                            sda_sample,
    output i2cbe_pkg::result_t              result
);

    logic [i2cbe_pkg::UNIT_W-1:0]  unit_ticks_reg;
    logic [i2cbe_pkg::LIMIT_W-1:0] ack_poll_limit_reg;

    i2cbe_pkg::phase_t             phase_reg, phase_next;
    logic [i2cbe_pkg::UNIT_W-1:0]  tick_reg, tick_next;
    logic [i2cbe_pkg::UCNT_W-1:0]  unit_reg, unit_next;
    logic [i2cbe_pkg::BIT_W-1:0]   bit_reg, bit_next;
    logic [i2cbe_pkg::BYTE_W-1:0]  shift_reg, shift_next;
    logic [i2cbe_pkg::LIMIT_W-1:0] poll_reg, poll_next;
    logic                          ack_choice_reg, ack_choice_next;
    logic                          scl_reg, scl_next;
    logic                          sda_reg, sda_next;
    logic                          fail_reg, fail_next;
    logic [i2cbe_pkg::BYTE_W-1:0]  rx_reg, rx_next;
    logic                          done;

    logic [i2cbe_pkg::UNIT_W-1:0]  unit_eff;
    logic [i2cbe_pkg::UNIT_W-1:0]  tick_inc;

    // a unit length of zero counts as one tick
    assign unit_eff = (unit_ticks_reg == '0) ? i2cbe_pkg::UNIT_W'(1) : unit_ticks_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        unit_next       = unit_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        poll_next       = poll_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        fail_next       = fail_reg;
        rx_next         = rx_reg;
        done            = 1'b0;
        tick_inc        = tick_reg + i2cbe_pkg::UNIT_W'(1);

        if (phase_reg == i2cbe_pkg::PH_IDLE)
        begin
            bit_next = '0;
            case (cmd)
                i2cbe_pkg::CMD_START:
                begin
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                    phase_next = i2cbe_pkg::PH_ST1;
                    unit_next  = i2cbe_pkg::UNITS_4;
                    tick_next  = '0;
                end
                i2cbe_pkg::CMD_STOP:
                begin
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = i2cbe_pkg::PH_SP1;
                    unit_next  = i2cbe_pkg::UNITS_4;
                    tick_next  = '0;
                end
                i2cbe_pkg::CMD_SEND:
                begin
                    shift_next = tx_byte;
                    scl_next   = 1'b0;
                    sda_next   = tx_byte[i2cbe_pkg::BYTE_W-1];
                    phase_next = i2cbe_pkg::PH_TXD;
                    unit_next  = i2cbe_pkg::UNITS_2;
                    tick_next  = '0;
                end
                i2cbe_pkg::CMD_WACK:
                begin
                    fail_next  = 1'b0;
                    poll_next  = '0;
                    sda_next   = 1'b1;
                    phase_next = i2cbe_pkg::PH_WA1;
                    unit_next  = i2cbe_pkg::UNITS_1;
                    tick_next  = '0;
                end
                i2cbe_pkg::CMD_READ:
                begin
                    ack_choice_next = send_ack;
                    shift_next      = '0;
                    sda_next        = 1'b1;
                    scl_next        = 1'b0;
                    phase_next      = i2cbe_pkg::PH_RDL;
                    unit_next       = i2cbe_pkg::UNITS_2;
                    tick_next       = '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (phase_reg != i2cbe_pkg::PH_POLL)
            begin
                if (tick_inc >= unit_eff)
                begin
                    tick_next = '0;
                    unit_next = unit_reg - i2cbe_pkg::UCNT_W'(1);
                    if (unit_next == '0)
                    begin
                        case (phase_reg)
                            i2cbe_pkg::PH_ST1:
                            begin
                                sda_next   = 1'b0;
                                phase_next = i2cbe_pkg::PH_ST2;
                                unit_next  = i2cbe_pkg::UNITS_4;
                            end
                            i2cbe_pkg::PH_ST2:
                            begin
                                scl_next   = 1'b0;
                                phase_next = i2cbe_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                            i2cbe_pkg::PH_SP1:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbe_pkg::PH_SP2;
                                unit_next  = i2cbe_pkg::UNITS_4;
                            end
                            i2cbe_pkg::PH_SP2:
                            begin
                                sda_next   = 1'b1;
                                phase_next = i2cbe_pkg::PH_SP3;
                                unit_next  = i2cbe_pkg::UNITS_4;
                            end
                            i2cbe_pkg::PH_TXD:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbe_pkg::PH_TXH;
                                unit_next  = i2cbe_pkg::UNITS_2;
                            end
                            i2cbe_pkg::PH_TXH:
                            begin
                                scl_next   = 1'b0;
                                phase_next = i2cbe_pkg::PH_TXL;
                                unit_next  = i2cbe_pkg::UNITS_2;
                            end
                            i2cbe_pkg::PH_TXL:
                            begin
                                shift_next = {shift_reg[i2cbe_pkg::BYTE_W-2:0], 1'b0};
                                bit_next   = bit_reg + i2cbe_pkg::BIT_W'(1);
                                if (bit_next >= i2cbe_pkg::BITS_PER_BYTE)
                                begin
                                    phase_next = i2cbe_pkg::PH_IDLE;
                                    done       = 1'b1;
                                end
                                else
                                begin
                                    scl_next   = 1'b0;
                                    sda_next   = shift_reg[i2cbe_pkg::BYTE_W-2];
                                    phase_next = i2cbe_pkg::PH_TXD;
                                    unit_next  = i2cbe_pkg::UNITS_2;
                                end
                            end
                            i2cbe_pkg::PH_WA1:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbe_pkg::PH_WA2;
                                unit_next  = i2cbe_pkg::UNITS_1;
                            end
                            i2cbe_pkg::PH_WA2:
                            begin
                                phase_next = i2cbe_pkg::PH_POLL;
                                unit_next  = i2cbe_pkg::UNITS_0;
                            end
                            i2cbe_pkg::PH_RDL:
                            begin
                                scl_next   = 1'b1;
                                shift_next = {shift_reg[i2cbe_pkg::BYTE_W-2:0], sda_sample};
                                bit_next   = bit_reg + i2cbe_pkg::BIT_W'(1);
                                phase_next = i2cbe_pkg::PH_RDH;
                                unit_next  = i2cbe_pkg::UNITS_1;
                            end
                            i2cbe_pkg::PH_RDH:
                            begin
                                scl_next = 1'b0;
                                unit_next = i2cbe_pkg::UNITS_2;
                                if (bit_reg >= i2cbe_pkg::BITS_PER_BYTE)
                                begin
                                    sda_next   = ~ack_choice_reg;
                                    phase_next = i2cbe_pkg::PH_AKL;
                                end
                                else
                                begin
                                    phase_next = i2cbe_pkg::PH_RDL;
                                end
                            end
                            i2cbe_pkg::PH_AKL:
                            begin
                                scl_next   = 1'b1;
                                phase_next = i2cbe_pkg::PH_AKH;
                                unit_next  = i2cbe_pkg::UNITS_2;
                            end
                            i2cbe_pkg::PH_AKH:
                            begin
                                scl_next   = 1'b0;
                                rx_next    = shift_reg;
                                phase_next = i2cbe_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                            default:
                            begin
                                phase_next = i2cbe_pkg::PH_IDLE;
                                done       = 1'b1;
                            end
                        endcase
                        if (done)
                        begin
                            unit_next = '0;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end

            // polling starts on the tick the wait segment ends
            if (phase_next == i2cbe_pkg::PH_POLL)
            begin
                if (!sda_sample)
                begin
                    scl_next   = 1'b0;
                    phase_next = i2cbe_pkg::PH_IDLE;
                    unit_next  = '0;
                    tick_next  = '0;
                    done       = 1'b1;
                end
                else if (poll_reg >= ack_poll_limit_reg)
                begin
                    fail_next  = 1'b1;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                    phase_next = i2cbe_pkg::PH_SP1;
                    unit_next  = i2cbe_pkg::UNITS_4;
                    tick_next  = '0;
                end
                else
                begin
                    poll_next = poll_reg + i2cbe_pkg::LIMIT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg     <= i2cbe_pkg::UNIT_TICKS_RST;
            ack_poll_limit_reg <= i2cbe_pkg::ACK_POLL_LIMIT_RST;
            phase_reg          <= i2cbe_pkg::PH_IDLE;
            tick_reg           <= '0;
            unit_reg           <= '0;
            bit_reg            <= '0;
            shift_reg          <= '0;
            poll_reg           <= '0;
            ack_choice_reg     <= 1'b0;
            scl_reg            <= 1'b1;
            sda_reg            <= 1'b1;
            fail_reg           <= 1'b0;
            rx_reg             <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    i2cbe_pkg::REG_UNIT_TICKS:
                        unit_ticks_reg <= cfg_data;
                    i2cbe_pkg::REG_ACK_POLL_LIMIT:
                        ack_poll_limit_reg <= cfg_data[i2cbe_pkg::LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (take)
            begin
                phase_reg      <= phase_next;
                tick_reg       <= tick_next;
                unit_reg       <= unit_next;
                bit_reg        <= bit_next;
                shift_reg      <= shift_next;
                poll_reg       <= poll_next;
                ack_choice_reg <= ack_choice_next;
                scl_reg        <= scl_next;
                sda_reg        <= sda_next;
                fail_reg       <= fail_next;
                rx_reg         <= rx_next;
            end
        end
    end

    assign result.scl_level = scl_next;
    assign result.sda_level = sda_next;
    assign result.busy_res  = (phase_next != i2cbe_pkg::PH_IDLE);
    assign result.done_res  = done;
    assign result.rx_byte   = rx_next;
    assign result.ack_fail  = fail_next;

endmodule

@@ hdl/i2cbe_out.sv @@
// ----------------------------------------------------------------------------
// i2cbe_out
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
module i2cbe_out
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  i2cbe_pkg::result_t res_in,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               can_load,
    output i2cbe_pkg::result_t res_out
);

    logic               valid_reg;
    i2cbe_pkg::result_t res_reg;

    // room when empty or the held transaction leaves this cycle
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

@@ hdl/i2c_master_bit_engine_unit.sv @@
// an accepted tick's result is held in the output register from the next cycle
// throughput: one tick per cycle (core state update) while in_ready is high
// the result register takes a new tick while the consumer drains the old one
// reset (rst_n low, async): bus idle, scl and sda released, counters cleared,
// unit_ticks and ack_poll_limit back to 250, no result pending
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// i2c master bit engine: start, stop, byte send/receive and ack polling
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [i2cbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cbe_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [i2cbe_pkg::CMD_W-1:0]     cmd,
    input  logic [i2cbe_pkg::BYTE_W-1:0]    tx_byte,
    input  logic                            send_ack,
    input  logic                            sda_sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            scl_level,
    output logic                            sda_level,
    output logic                            busy_res,
    output logic                            done_res,
    output logic [i2cbe_pkg::BYTE_W-1:0]    rx_byte,
    output logic                            ack_fail
);

    logic               take;
    i2cbe_pkg::result_t res_comb;
    i2cbe_pkg::result_t res_held;

    assign take = in_valid && in_ready;

    i2cbe_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .cmd        (cmd),
        .tx_byte    (tx_byte),
        .send_ack   (send_ack),
        .sda_sample (sda_sample),
        .result     (res_comb)
    );

    i2cbe_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .res_in    (res_comb),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (in_ready),
        .res_out   (res_held)
    );

    assign scl_level = res_held.scl_level;
    assign sda_level = res_held.sda_level;
    assign busy_res  = res_held.busy_res;
    assign done_res  = res_held.done_res;
    assign rx_byte   = res_held.rx_byte;
    assign ack_fail  = res_held.ack_fail;

endmodule
